[src/tct_pkg.sv]
// Shared types and constants for the tracker channel tick block.
// Holds the word structs, action and effect codes, and the amplitude table.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package tct_pkg;

    localparam int NOTE_COUNT = 96;
    localparam int NOTE_AW    = $clog2(NOTE_COUNT);
    localparam logic [NOTE_AW-1:0] NOTE_LAST = NOTE_AW'(NOTE_COUNT - 1);

    typedef enum logic [3:0] {
        ACT_TICK   = 4'd0,
        ACT_NOTE   = 4'd1,
        ACT_GLIDE  = 4'd2,
        ACT_PORTA  = 4'd3,
        ACT_GATE   = 4'd4,
        ACT_SAVE   = 4'd5,
        ACT_VOLUME = 4'd6,
        ACT_ENV_ON = 4'd7,
        ACT_ENV_OFF = 4'd8,
        ACT_TABLE  = 4'd9
    } action_t;

    typedef enum logic [1:0] {
        EFF_NONE  = 2'd0,
        EFF_GLIDE = 2'd1,
        EFF_PORTA = 2'd2,
        EFF_GATE  = 2'd3
    } effect_t;

    typedef enum logic {
        CFG_CHANNEL_INDEX = 1'b0,
        CFG_SPECIAL_MODE  = 1'b1
    } cfg_reg_t;

    localparam logic [3:0]  SPECIAL_MASK_IN  = 4'h9;
    localparam logic [3:0]  SPECIAL_MASK_OUT = 4'h8;
    localparam logic [11:0] SPECIAL_TONE     = 12'h001;
    localparam logic [4:0]  AMP_ENVELOPE     = 5'h10;

    typedef struct packed {
        logic [3:0]  action;
        logic [6:0]  note_index;
        logic [7:0]  effect_delay;
        logic [7:0]  gate_off_time;
        logic [15:0] value_word;
        logic [3:0]  base_volume;
        logic signed [15:0] sample_tone_shift;
        logic [4:0]  sample_volume;
        logic [3:0]  sample_mask;
        logic [7:0]  noise_value;
        logic signed [7:0]  ornament_shift;
    } in_word_t;

    typedef struct packed {
        logic [3:0]  period_high;
        logic [7:0]  period_low;
        logic [5:0]  mixer_bits;
        logic [4:0]  amplitude;
        logic        noise_valid;
        logic [7:0]  noise_out;
        logic        envelope_valid;
        logic [15:0] envelope_out;
    } out_word_t;

    typedef struct packed {
        logic [1:0] channel_index;
        logic       special_chip_mode;
    } cfg_t;

    // Word held between the front end and the effect engine, with both
    // period table reads that were issued when it was accepted.
    typedef struct packed {
        logic        valid;
        in_word_t    data;
        logic [15:0] period_a;
        logic [15:0] period_b;
    } issue_t;

    // Amplitude by base volume (upper index bits) and sample level (lower bits).
    localparam logic [3:0] AMP_TABLE [0:255] = '{
        0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,
        0,0,0,0,0,0,0,0,1,1,1,1,1,1,1,1,
        0,0,0,0,1,1,1,1,1,1,1,1,2,2,2,2,
        0,0,0,1,1,1,1,1,2,2,2,2,2,3,3,3,
        0,0,1,1,1,1,2,2,2,2,3,3,3,3,4,4,
        0,0,1,1,1,2,2,2,3,3,3,4,4,4,5,5,
        0,0,1,1,2,2,2,3,3,4,4,4,5,5,6,6,
        0,0,1,1,2,2,3,3,4,4,5,5,6,6,7,7,
        0,1,1,2,2,3,3,4,4,5,5,6,6,7,7,8,
        0,1,1,2,2,3,4,4,5,5,6,7,7,8,8,9,
        0,1,1,2,3,3,4,5,5,6,7,7,8,9,9,10,
        0,1,1,2,3,4,4,5,6,7,7,8,9,10,10,11,
        0,1,2,2,3,4,5,6,6,7,8,9,10,10,11,12,
        0,1,2,3,3,4,5,6,7,8,9,10,10,11,12,13,
        0,1,2,3,4,5,6,7,7,8,9,10,11,12,13,14,
        0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15
    };

endpackage

`default_nettype wire

[src/tct_period_ram.sv]
// Period table memory: one write port and two registered read ports.
// Depends on tct_pkg for the depth and address width.
`default_nettype none

module tct_period_ram (
    input  wire logic                       aclk,
    input  wire logic                       wr_en,
    input  wire logic [tct_pkg::NOTE_AW-1:0] wr_addr,
    input  wire logic [15:0]                wr_data,
    input  wire logic                       rd_en,
    input  wire logic [tct_pkg::NOTE_AW-1:0] rd_addr_a,
    input  wire logic [tct_pkg::NOTE_AW-1:0] rd_addr_b,
    output logic [15:0]                     rd_data_a,
    output logic [15:0]                     rd_data_b
);
    import tct_pkg::*;

    logic [15:0] mem [0:NOTE_COUNT-1];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

`default_nettype wire

[src/tct_front.sv]
// Front end: note registers, period table addressing and the input register.
// Depends on tct_pkg and instantiates tct_period_ram.
`default_nettype none

module tct_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             accept,
    input  wire logic             take,
    input  wire tct_pkg::in_word_t s_data,
    output tct_pkg::issue_t       issue
);
    import tct_pkg::*;

    logic [6:0]          note_base_reg, note_base_next;
    logic [6:0]          saved_note_reg, saved_note_next;
    logic                valid_reg, valid_next;
    in_word_t            data_reg;
    logic signed [8:0]   note_sum;
    logic [NOTE_AW-1:0]  tick_addr;
    logic [NOTE_AW-1:0]  base_addr;
    logic [NOTE_AW-1:0]  saved_addr;
    logic [NOTE_AW-1:0]  addr_a;
    logic                wr_en;
    logic [15:0]         period_a, period_b;

    // Reads beyond the table saturate to the last entry.
    function automatic logic [NOTE_AW-1:0] sat_addr(input logic [6:0] n);
        logic [NOTE_AW-1:0] r;
        if ({1'b0, n} >= 8'(NOTE_COUNT)) begin
            r = NOTE_LAST;
        end else begin
            r = NOTE_AW'(n);
        end
        return r;
    endfunction

    always_comb begin
        note_sum = $signed({2'b00, note_base_reg}) + 9'(s_data.ornament_shift);
        if (note_sum < 0) begin
            tick_addr = '0;
        end else if (note_sum > $signed(9'(NOTE_COUNT - 1))) begin
            tick_addr = NOTE_LAST;
        end else begin
            tick_addr = NOTE_AW'(note_sum);
        end
    end

    assign base_addr  = sat_addr(note_base_reg);
    assign saved_addr = sat_addr(saved_note_reg);
    assign addr_a     = (s_data.action == ACT_PORTA) ? saved_addr : tick_addr;
    assign wr_en      = accept && (s_data.action == ACT_TABLE)
                        && ({1'b0, s_data.note_index} < 8'(NOTE_COUNT));

    tct_period_ram u_ram (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (NOTE_AW'(s_data.note_index)),
        .wr_data   (s_data.value_word),
        .rd_en     (accept),
        .rd_addr_a (addr_a),
        .rd_addr_b (base_addr),
        .rd_data_a (period_a),
        .rd_data_b (period_b)
    );

    // Note registers depend only on the word and the front end's own state, so they update at accept
    // and the next word already addresses the table with the new note.
    always_comb begin
        note_base_next  = note_base_reg;
        saved_note_next = saved_note_reg;
        if (accept && s_data.action == ACT_NOTE) begin
            note_base_next = s_data.note_index;
        end
        if (accept && s_data.action == ACT_SAVE) begin
            saved_note_next = note_base_reg;
        end
        if (accept) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            note_base_reg  <= '0;
            saved_note_reg <= '0;
            valid_reg      <= 1'b0;
        end else begin
            note_base_reg  <= note_base_next;
            saved_note_reg <= saved_note_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            data_reg <= s_data;
        end
    end

    assign issue.valid    = valid_reg;
    assign issue.data     = data_reg;
    assign issue.period_a = period_a;
    assign issue.period_b = period_b;

endmodule

`default_nettype wire

[src/tct_engine.sv]
// Effect engine: applies glide, portamento and gate, forms the chip values
// and holds the result register. Depends on tct_pkg.
`default_nettype none

module tct_engine (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire tct_pkg::issue_t   issue,
    input  wire tct_pkg::cfg_t     cfg,
    output logic                   take,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output tct_pkg::out_word_t     m_data
);
    import tct_pkg::*;

    logic [15:0] acc_shift_reg,   acc_shift_next;
    logic [15:0] saved_shift_reg, saved_shift_next;
    logic [15:0] porta_step_reg,  porta_step_next;
    logic [15:0] glide_step_reg,  glide_step_next;
    effect_t     effect_kind_reg, effect_kind_next;
    logic [15:0] effect_ticks_reg, effect_ticks_next;
    logic [7:0]  delay_reg,       delay_next;
    logic [7:0]  off_time_reg,    off_time_next;
    logic [3:0]  volume_reg,      volume_next;
    logic        envelope_on_reg, envelope_on_next;
    logic        m_valid_reg;
    out_word_t   m_data_reg;

    in_word_t    w;
    logic        is_tick;
    logic        load;
    logic [15:0] porta_acc;
    logic [15:0] tick_plus;
    logic [15:0] glide_ticks;
    logic [16:0] acc_mag, step_mag;
    logic [8:0]  gate_span;
    logic [15:0] tone_shift;
    logic [4:0]  level;
    logic [15:0] tone;
    logic [11:0] tone_out;
    logic [3:0]  mask;
    logic [6:0]  mask_shifted;
    logic        env_mode;
    logic        env_valid;
    out_word_t   result;

    function automatic logic [16:0] magnitude(input logic [15:0] v);
        logic [16:0] s;
        s = {v[15], v};
        return v[15] ? (~s + 17'd1) : s;
    endfunction

    assign w       = issue.data;
    assign is_tick = (w.action == ACT_TICK);
    assign take    = issue.valid && (!is_tick || !m_valid_reg || m_ready);
    assign load    = take && is_tick;

    assign porta_acc = issue.period_a - issue.period_b + saved_shift_reg;
    assign tick_plus = effect_ticks_reg + 16'd1;
    assign acc_mag   = magnitude(acc_shift_reg);
    assign step_mag  = magnitude(porta_step_reg);
    assign gate_span = {1'b0, delay_reg} + {1'b0, off_time_reg};

    always_comb begin
        acc_shift_next    = acc_shift_reg;
        saved_shift_next  = saved_shift_reg;
        porta_step_next   = porta_step_reg;
        glide_step_next   = glide_step_reg;
        effect_kind_next  = effect_kind_reg;
        effect_ticks_next = effect_ticks_reg;
        delay_next        = delay_reg;
        off_time_next     = off_time_reg;
        volume_next       = volume_reg;
        envelope_on_next  = envelope_on_reg;
        tone_shift        = w.sample_tone_shift;
        level             = w.sample_volume;
        glide_ticks       = effect_ticks_reg;

        unique case (w.action)
            ACT_TICK: begin
                unique case (effect_kind_reg)
                    EFF_GLIDE: begin
                        if (effect_ticks_reg >= {8'd0, delay_reg} && delay_reg != 8'd0) begin
                            acc_shift_next = acc_shift_reg + glide_step_reg;
                            glide_ticks    = '0;
                        end
                        tone_shift        = w.sample_tone_shift + acc_shift_next;
                        effect_ticks_next = glide_ticks + 16'd1;
                    end
                    EFF_PORTA: begin
                        effect_ticks_next = tick_plus;
                        // The slide ends once the remaining distance is under one step.
                        if (acc_shift_reg == 16'd0 || acc_mag < step_mag) begin
                            effect_kind_next = EFF_NONE;
                            acc_shift_next   = '0;
                        end else begin
                            if (tick_plus >= {8'd0, delay_reg}) begin
                                acc_shift_next    = acc_shift_reg + porta_step_reg;
                                effect_ticks_next = '0;
                            end
                            tone_shift = w.sample_tone_shift + acc_shift_next;
                        end
                    end
                    EFF_GATE: begin
                        if (effect_ticks_reg < {8'd0, off_time_reg}
                            || (off_time_reg == 8'd0
                                && effect_ticks_reg >= {8'd0, delay_reg})) begin
                            level = '0;
                        end
                        effect_ticks_next = tick_plus;
                        if (off_time_reg != 8'd0 && tick_plus > {7'd0, gate_span}) begin
                            effect_ticks_next = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ACT_NOTE: begin
                effect_kind_next = EFF_NONE;
                acc_shift_next   = '0;
            end
            ACT_GLIDE: begin
                effect_kind_next  = EFF_GLIDE;
                delay_next        = w.effect_delay;
                glide_step_next   = w.value_word;
                effect_ticks_next = '0;
            end
            ACT_PORTA: begin
                acc_shift_next = porta_acc;
                // The step must point from the saved note back toward the current note.
                if ((porta_acc[15] && w.value_word[15])
                    || (!porta_acc[15] && porta_acc != 16'd0
                        && !w.value_word[15] && w.value_word != 16'd0)) begin
                    porta_step_next = ~w.value_word + 16'd1;
                end else begin
                    porta_step_next = w.value_word;
                end
                effect_kind_next  = EFF_PORTA;
                delay_next        = w.effect_delay;
                effect_ticks_next = '0;
            end
            ACT_GATE: begin
                effect_kind_next  = EFF_GATE;
                delay_next        = w.effect_delay;
                off_time_next     = w.gate_off_time;
                effect_ticks_next = '0;
            end
            ACT_SAVE: begin
                saved_shift_next = acc_shift_reg;
            end
            ACT_VOLUME: begin
                volume_next = w.base_volume;
            end
            ACT_ENV_ON: begin
                envelope_on_next = 1'b1;
            end
            ACT_ENV_OFF: begin
                envelope_on_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        tone     = issue.period_a + tone_shift;
        tone_out = tone[11:0];
        mask     = w.sample_mask;
        if (cfg.special_chip_mode && mask == SPECIAL_MASK_IN) begin
            tone_out = SPECIAL_TONE;
            mask     = SPECIAL_MASK_OUT;
        end
        mask_shifted = {3'b000, mask} << cfg.channel_index;
        env_mode     = level[4] && envelope_on_reg;
        env_valid    = (w.value_word != 16'd0) && envelope_on_reg;

        result.period_high    = tone_out[11:8];
        result.period_low     = tone_out[7:0];
        result.mixer_bits     = mask_shifted[5:0];
        result.amplitude      = env_mode ? AMP_ENVELOPE
                                         : {1'b0, AMP_TABLE[{volume_reg, level[3:0]}]};
        result.noise_valid    = (w.noise_value != 8'd0);
        result.noise_out      = w.noise_value;
        result.envelope_valid = env_valid;
        result.envelope_out   = env_valid ? w.value_word : 16'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_shift_reg    <= '0;
            saved_shift_reg  <= '0;
            porta_step_reg   <= '0;
            glide_step_reg   <= '0;
            effect_kind_reg  <= EFF_NONE;
            effect_ticks_reg <= '0;
            delay_reg        <= '0;
            off_time_reg     <= '0;
            volume_reg       <= 4'hF;
            envelope_on_reg  <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (take) begin
                acc_shift_reg    <= acc_shift_next;
                saved_shift_reg  <= saved_shift_next;
                porta_step_reg   <= porta_step_next;
                glide_step_reg   <= glide_step_next;
                effect_kind_reg  <= effect_kind_next;
                effect_ticks_reg <= effect_ticks_next;
                delay_reg        <= delay_next;
                off_time_reg     <= off_time_next;
                volume_reg       <= volume_next;
                envelope_on_reg  <= envelope_on_next;
            end
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

[src/tracker_channel_tick.sv]
// Top level of one tracker channel: configuration registers, front end and engine.
// Depends on tct_pkg, tct_front and tct_engine.
`default_nettype none

// Accepts one word per clock unless a tick word is held waiting for the output,
// and returns one result word for each tick word. Other words update the channel
// state and return nothing. A word is captured in the input register while its
// period table reads, issued at acceptance, are registered; a tick word then loads
// the result register behind the effect logic once the output is free. The period
// table has no reset and must be loaded before any note that reads it is played.
// Configuration writes are always taken and should only be issued while the
// channel is idle.
module tracker_channel_tick (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire tct_pkg::in_word_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output tct_pkg::out_word_t      m_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [1:0]         cfg_data
);
    import tct_pkg::*;

    logic [1:0] channel_index_reg;
    logic       special_mode_reg;
    cfg_t       cfg;
    issue_t     issue;
    logic       take;
    logic       accept;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_index_reg <= '0;
            special_mode_reg  <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_CHANNEL_INDEX: channel_index_reg <= cfg_data;
                CFG_SPECIAL_MODE:  special_mode_reg  <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.channel_index     = channel_index_reg;
    assign cfg.special_chip_mode = special_mode_reg;

    assign s_ready = !issue.valid || take;
    assign accept  = s_valid && s_ready;

    tct_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .take    (take),
        .s_data  (s_data),
        .issue   (issue)
    );

    tct_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .issue   (issue),
        .cfg     (cfg),
        .take    (take),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for the tracker channel tick block.
// Depends on tct_pkg and tracker_channel_tick; a built-in channel predictor checks every tick word.
module testbench;
    import tct_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int TAIL_CYCLES   = 16;
    localparam int HOLD_CYCLES   = 250;
    localparam int RANDOM_WORDS  = 1300;
    localparam int SEND_AHEAD    = 4;

    localparam logic [3:0]  CHIP_MASK_IN  = 4'h9;
    localparam logic [3:0]  CHIP_MASK_OUT = 4'h8;
    localparam logic [15:0] CHIP_TONE     = 16'h0001;
    localparam logic [4:0]  ENV_LEVEL     = 5'h10;

    // Chip output level by base volume (upper nibble) and sample level (lower nibble).
    localparam bit [3:0] LEVEL_AMP [0:255] = '{
        0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,
        0,0,0,0,0,0,0,0,1,1,1,1,1,1,1,1,
        0,0,0,0,1,1,1,1,1,1,1,1,2,2,2,2,
        0,0,0,1,1,1,1,1,2,2,2,2,2,3,3,3,
        0,0,1,1,1,1,2,2,2,2,3,3,3,3,4,4,
        0,0,1,1,1,2,2,2,3,3,3,4,4,4,5,5,
        0,0,1,1,2,2,2,3,3,4,4,4,5,5,6,6,
        0,0,1,1,2,2,3,3,4,4,5,5,6,6,7,7,
        0,1,1,2,2,3,3,4,4,5,5,6,6,7,7,8,
        0,1,1,2,2,3,4,4,5,5,6,7,7,8,8,9,
        0,1,1,2,3,3,4,5,5,6,7,7,8,9,9,10,
        0,1,1,2,3,4,4,5,6,7,7,8,9,10,10,11,
        0,1,2,2,3,4,5,6,6,7,8,9,10,10,11,12,
        0,1,2,3,3,4,5,6,7,8,9,10,10,11,12,13,
        0,1,2,3,4,5,6,7,7,8,9,10,11,12,13,14,
        0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15
    };

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    in_word_t   s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    out_word_t  m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_index = 1'b0;
    logic [1:0] cfg_data  = 2'b00;

    always #4 aclk = ~aclk;

    tracker_channel_tick DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predicted channel state.
    logic [15:0] period_mem [0:NOTE_COUNT-1];
    logic [6:0]  cur_note      = '0;
    logic [6:0]  origin_note   = '0;
    logic [15:0] shift_acc     = '0;
    logic [15:0] origin_shift  = '0;
    logic [15:0] porta_delta   = '0;
    logic [15:0] glide_delta   = '0;
    effect_t     cur_effect    = EFF_NONE;
    logic [15:0] tick_count    = '0;
    logic [7:0]  step_delay    = '0;
    logic [7:0]  gate_off      = '0;
    logic [3:0]  chan_volume   = 4'd15;
    logic        env_enabled   = 1'b0;
    logic [1:0]  voice_pos     = '0;
    logic        chip_mode     = 1'b0;

    in_word_t  words_to_send [$];
    out_word_t tick_results_due [$];
    int        send_gap    = 0;
    int        stall_left  = 0;
    int        hold_left   = 0;
    int        idle_pct    = 0;
    int        words_sent  = 0;
    int        mismatches  = 0;
    int        cycle_count = 0;

    function automatic logic [15:0] period_at(int unsigned idx);
        if (idx >= NOTE_COUNT)
            idx = NOTE_COUNT - 1;
        return period_mem[idx];
    endfunction

    function automatic int mag16(logic [15:0] v);
        int s;
        s = $signed(v);
        return (s < 0) ? -s : s;
    endfunction

    // Applies one word to the predicted state; returns 1 with the chip values for a tick.
    function automatic bit channel_step(input in_word_t w, output out_word_t r);
        logic [15:0] diff;
        logic [15:0] delta;
        logic [15:0] tone_ofs;
        logic [15:0] tone;
        logic [4:0]  level;
        logic [3:0]  mask;
        logic [7:0]  mask_wide;
        int          acc;
        int          st;
        int          idx;
        int          orn;
        bit          env_mode;
        r = '0;
        case (w.action)
            ACT_NOTE: begin
                cur_effect = EFF_NONE;
                cur_note = w.note_index;
                shift_acc = '0;
                return 0;
            end
            ACT_GLIDE: begin
                cur_effect = EFF_GLIDE;
                step_delay = w.effect_delay;
                glide_delta = w.value_word;
                tick_count = '0;
                return 0;
            end
            ACT_PORTA: begin
                diff = period_at(origin_note) - period_at(cur_note);
                shift_acc = diff + origin_shift;
                acc = $signed(shift_acc);
                st = $signed(w.value_word);
                delta = w.value_word;
                // The step always points back toward the target note.
                if ((acc < 0 && st < 0) || (acc > 0 && st > 0))
                    delta = 16'd0 - w.value_word;
                porta_delta = delta;
                cur_effect = EFF_PORTA;
                step_delay = w.effect_delay;
                tick_count = '0;
                return 0;
            end
            ACT_GATE: begin
                cur_effect = EFF_GATE;
                step_delay = w.effect_delay;
                gate_off = w.gate_off_time;
                tick_count = '0;
                return 0;
            end
            ACT_SAVE: begin
                origin_shift = shift_acc;
                origin_note = cur_note;
                return 0;
            end
            ACT_VOLUME: begin
                chan_volume = w.base_volume;
                return 0;
            end
            ACT_ENV_ON: begin
                env_enabled = 1'b1;
                return 0;
            end
            ACT_ENV_OFF: begin
                env_enabled = 1'b0;
                return 0;
            end
            ACT_TABLE: begin
                if (w.note_index < NOTE_COUNT)
                    period_mem[w.note_index] = w.value_word;
                return 0;
            end
            ACT_TICK: ;
            default: return 0;
        endcase

        tone_ofs = w.sample_tone_shift;
        level = w.sample_volume;
        mask = w.sample_mask;
        if (cur_effect == EFF_GLIDE) begin
            if (tick_count >= step_delay && step_delay != 0) begin
                shift_acc = shift_acc + glide_delta;
                tick_count = '0;
            end
            tone_ofs = tone_ofs + shift_acc;
            tick_count = tick_count + 16'd1;
        end else if (cur_effect == EFF_PORTA) begin
            acc = $signed(shift_acc);
            tick_count = tick_count + 16'd1;
            if (acc == 0 || mag16(shift_acc) < mag16(porta_delta)) begin
                cur_effect = EFF_NONE;
                shift_acc = '0;
            end else begin
                if (tick_count >= step_delay) begin
                    shift_acc = shift_acc + porta_delta;
                    tick_count = '0;
                end
                tone_ofs = tone_ofs + shift_acc;
            end
        end else if (cur_effect == EFF_GATE) begin
            if (tick_count < gate_off || (gate_off == 0 && tick_count >= step_delay))
                level = '0;
            tick_count = tick_count + 16'd1;
            if (gate_off != 0 && tick_count > {8'd0, step_delay} + {8'd0, gate_off})
                tick_count = '0;
        end

        orn = w.ornament_shift;
        idx = cur_note;
        idx = idx + orn;
        if (idx < 0)
            idx = 0;
        else if (idx > NOTE_COUNT - 1)
            idx = NOTE_COUNT - 1;
        tone = period_at(idx) + tone_ofs;
        if (chip_mode && mask == CHIP_MASK_IN) begin
            tone = CHIP_TONE;
            mask = CHIP_MASK_OUT;
        end

        env_mode = level[4] && env_enabled;
        mask_wide = {4'd0, mask} << voice_pos;
        r.period_high = tone[11:8];
        r.period_low = tone[7:0];
        r.mixer_bits = mask_wide[5:0];
        r.amplitude = env_mode ? ENV_LEVEL : {1'b0, LEVEL_AMP[{chan_volume, level[3:0]}]};
        r.noise_valid = (w.noise_value != 0);
        r.noise_out = w.noise_value;
        if (w.value_word != 0 && env_enabled) begin
            r.envelope_valid = 1'b1;
            r.envelope_out = w.value_word;
        end
        return 1;
    endfunction

    // Source side: feeds queued words, with random gaps when idling is on.
    always @(posedge aclk) begin : source
        out_word_t res;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (channel_step(s_data, res))
                    tick_results_due.push_back(res);
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (words_to_send.size() > 0 && idle_pct > 0 &&
                             $urandom_range(99) < idle_pct) begin
                    send_gap = $urandom_range(0, 6);
                    s_valid <= 1'b0;
                end else if (words_to_send.size() > 0) begin
                    s_valid <= 1'b1;
                    s_data <= words_to_send.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report(input string what, input int unsigned want, input int unsigned got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0d, got %0d", what, want, got);
    endtask

    // Sink side: checks every result word and throttles m_ready.
    always @(posedge aclk) begin : sink
        out_word_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (tick_results_due.size() == 0) begin
                    report("unexpected result word", 0, 1);
                end else begin
                    want = tick_results_due.pop_front();
                    if (m_data.period_high !== want.period_high)
                        report("period_high", want.period_high, m_data.period_high);
                    if (m_data.period_low !== want.period_low)
                        report("period_low", want.period_low, m_data.period_low);
                    if (m_data.mixer_bits !== want.mixer_bits)
                        report("mixer_bits", want.mixer_bits, m_data.mixer_bits);
                    if (m_data.amplitude !== want.amplitude)
                        report("amplitude", want.amplitude, m_data.amplitude);
                    if (m_data.noise_valid !== want.noise_valid)
                        report("noise_valid", want.noise_valid, m_data.noise_valid);
                    if (m_data.noise_out !== want.noise_out)
                        report("noise_out", want.noise_out, m_data.noise_out);
                    if (m_data.envelope_valid !== want.envelope_valid)
                        report("envelope_valid", want.envelope_valid, m_data.envelope_valid);
                    if (m_data.envelope_out !== want.envelope_out)
                        report("envelope_out", want.envelope_out, m_data.envelope_out);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
                stall_left = $urandom_range(0, 6);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_word(input in_word_t w);
        while (words_to_send.size() >= SEND_AHEAD)
            @(posedge aclk);
        words_to_send.push_back(w);
        words_sent++;
    endtask

    // Waits until every queued word is taken and every tick result has come back.
    task automatic settle();
        while (words_to_send.size() != 0 || s_valid || send_gap != 0)
            @(posedge aclk);
        while (tick_results_due.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input cfg_reg_t idx, input logic [1:0] val);
        settle();
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge aclk);
        while (!cfg_ready);
        if (idx == CFG_CHANNEL_INDEX)
            voice_pos = val;
        else
            chip_mode = val[0];
        cfg_valid <= 1'b0;
    endtask

    function automatic in_word_t fresh_word(input action_t a);
        logic [95:0] bits;
        in_word_t w;
        bits = {$urandom, $urandom, $urandom};
        w = bits[87:0];
        w.action = a;
        return w;
    endfunction

    function automatic in_word_t tick_word();
        in_word_t w;
        w = fresh_word(ACT_TICK);
        if ($urandom_range(0, 9) < 7)
            w.ornament_shift = 8'($urandom_range(0, 24) - 12);
        if ($urandom_range(0, 1) == 0)
            w.sample_tone_shift = 16'($urandom_range(0, 128) - 64);
        if ($urandom_range(0, 3) == 0)
            w.value_word = '0;
        return w;
    endfunction

    function automatic logic [7:0] short_or_full(input int short_max);
        if ($urandom_range(0, 99) < 85)
            return 8'($urandom_range(0, short_max));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] step_value();
        int v;
        if ($urandom_range(0, 9) < 8) begin
            v = $urandom_range(0, 400);
            v = v - 200;
            return 16'(v);
        end
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic test_table_load();
        in_word_t w;
        for (int i = 0; i < NOTE_COUNT; i++) begin
            w = fresh_word(ACT_TABLE);
            w.note_index = 7'(i);
            w.value_word = (i % 8 == 0) ? 16'($urandom) : 16'($urandom_range(0, 4095));
            send_word(w);
        end
    endtask

    task automatic test_note_clamp();
        in_word_t w;
        w = fresh_word(ACT_NOTE);
        w.note_index = 0;
        send_word(w);
        w = fresh_word(ACT_TICK);
        w.ornament_shift = -128;
        w.sample_tone_shift = -32768;
        send_word(w);
        w = fresh_word(ACT_NOTE);
        w.note_index = NOTE_COUNT - 1;
        send_word(w);
        w = fresh_word(ACT_TICK);
        w.ornament_shift = 127;
        w.sample_tone_shift = 32767;
        send_word(w);
        // A note beyond the table reads the last entry.
        w = fresh_word(ACT_NOTE);
        w.note_index = 7'd127;
        send_word(w);
        w = fresh_word(ACT_TABLE);
        w.note_index = 7'd100;
        send_word(w);
        w = fresh_word(ACT_TICK);
        w.ornament_shift = 0;
        send_word(w);
        w = fresh_word(ACT_TICK);
        w.action = 4'd12;
        send_word(w);
        send_word(tick_word());
    endtask

    task automatic test_volume_envelope();
        in_word_t w;
        w = fresh_word(ACT_VOLUME);
        w.base_volume = 0;
        send_word(w);
        w = fresh_word(ACT_TICK);
        w.sample_volume = 5'h0F;
        send_word(w);
        w = fresh_word(ACT_VOLUME);
        w.base_volume = 15;
        send_word(w);
        send_word(fresh_word(ACT_ENV_ON));
        w = fresh_word(ACT_TICK);
        w.sample_volume = 5'h1F;
        w.value_word = 16'hFFFF;
        w.noise_value = 0;
        send_word(w);
        w.value_word = 0;
        w.noise_value = 8'hFF;
        send_word(w);
        send_word(fresh_word(ACT_ENV_OFF));
        w.value_word = 16'h1234;
        send_word(w);
    endtask

    task automatic test_effects();
        in_word_t w;
        w = fresh_word(ACT_NOTE);
        w.note_index = 40;
        send_word(w);
        w = fresh_word(ACT_GLIDE);
        w.effect_delay = 1;
        w.value_word = 16'd5;
        send_word(w);
        repeat (3) send_word(tick_word());
        send_word(fresh_word(ACT_SAVE));
        w = fresh_word(ACT_NOTE);
        w.note_index = 44;
        send_word(w);
        w = fresh_word(ACT_PORTA);
        w.effect_delay = 0;
        w.value_word = 16'd3;
        send_word(w);
        repeat (3) send_word(tick_word());
        // Origin equals the current note, so the slide starts from the saved shift alone.
        send_word(fresh_word(ACT_SAVE));
        w = fresh_word(ACT_PORTA);
        w.value_word = 16'd7;
        send_word(w);
        send_word(tick_word());
        w = fresh_word(ACT_GATE);
        w.effect_delay = 2;
        w.gate_off_time = 0;
        send_word(w);
        repeat (3) send_word(tick_word());
        w = fresh_word(ACT_GATE);
        w.effect_delay = 1;
        w.gate_off_time = 2;
        send_word(w);
        repeat (4) send_word(tick_word());
    endtask

    task automatic test_chip_mode();
        in_word_t w;
        cfg_write(CFG_CHANNEL_INDEX, 2'd3);
        cfg_write(CFG_SPECIAL_MODE, 2'd1);
        w = tick_word();
        w.sample_mask = CHIP_MASK_IN;
        send_word(w);
        w = tick_word();
        w.sample_mask = 4'hF;
        send_word(w);
        cfg_write(CFG_SPECIAL_MODE, 2'd2);
        w = tick_word();
        w.sample_mask = CHIP_MASK_IN;
        send_word(w);
        cfg_write(CFG_CHANNEL_INDEX, 2'd0);
    endtask

    task automatic test_backpressure();
        settle();
        idle_pct = 0;
        hold_left = HOLD_CYCLES;
        repeat (40) send_word(tick_word());
        settle();
    endtask

    task automatic test_source_pause();
        in_word_t w;
        idle_pct = 15;
        w = fresh_word(ACT_NOTE);
        w.note_index = 7'($urandom_range(0, NOTE_COUNT - 1));
        send_word(w);
        w = fresh_word(ACT_GLIDE);
        w.effect_delay = 2;
        send_word(w);
        repeat (5) send_word(tick_word());
        settle();
        repeat (6) send_word(tick_word());
    endtask

    // One musical phrase: optional setup words, a note, maybe an effect, ticks; or a random word.
    task automatic play_phrase();
        in_word_t w;
        int pick;
        if ($urandom_range(0, 99) < 12) begin
            w = fresh_word(ACT_TICK);
            w.action = 4'($urandom_range(0, 15));
            send_word(w);
            return;
        end
        if ($urandom_range(0, 4) == 0)
            send_word(fresh_word($urandom_range(0, 1) ? ACT_ENV_ON : ACT_ENV_OFF));
        if ($urandom_range(0, 4) == 0)
            send_word(fresh_word(ACT_VOLUME));
        if ($urandom_range(0, 9) == 0)
            send_word(fresh_word(ACT_TABLE));
        w = fresh_word(ACT_NOTE);
        if ($urandom_range(0, 9) != 0)
            w.note_index = 7'($urandom_range(0, NOTE_COUNT - 1));
        send_word(w);
        if ($urandom_range(0, 99) < 35) begin
            repeat ($urandom_range(0, 3)) send_word(tick_word());
            send_word(fresh_word(ACT_SAVE));
            w = fresh_word(ACT_NOTE);
            w.note_index = 7'($urandom_range(0, NOTE_COUNT - 1));
            send_word(w);
        end
        pick = $urandom_range(0, 3);
        if (pick == 1) begin
            w = fresh_word(ACT_GLIDE);
            w.effect_delay = short_or_full(3);
            w.value_word = step_value();
            send_word(w);
        end else if (pick == 2) begin
            w = fresh_word(ACT_PORTA);
            w.effect_delay = short_or_full(3);
            w.value_word = step_value();
            send_word(w);
        end else if (pick == 3) begin
            w = fresh_word(ACT_GATE);
            w.effect_delay = short_or_full(6);
            w.gate_off_time = short_or_full(6);
            send_word(w);
        end
        repeat ($urandom_range(3, 16)) send_word(tick_word());
    endtask

    task automatic test_random();
        int target;
        int phase;
        phase = 0;
        target = words_sent + RANDOM_WORDS;
        while (words_sent < target) begin
            case (phase)
                0: begin
                    cfg_write(CFG_CHANNEL_INDEX, 2'd0);
                    cfg_write(CFG_SPECIAL_MODE, 2'd0);
                end
                1: begin
                    cfg_write(CFG_CHANNEL_INDEX, 2'd3);
                    cfg_write(CFG_SPECIAL_MODE, 2'd3);
                end
                default: begin
                    cfg_write(CFG_CHANNEL_INDEX, 2'($urandom_range(0, 3)));
                    cfg_write(CFG_SPECIAL_MODE, 2'($urandom_range(0, 3)));
                end
            endcase
            idle_pct = (phase % 3 == 2) ? 0 : $urandom_range(5, 40);
            repeat (40) begin
                // The closing stretch runs without any idling.
                if (target - words_sent <= RANDOM_WORDS / 8)
                    idle_pct = 0;
                if (words_sent < target)
                    play_phrase();
            end
            phase++;
        end
        idle_pct = 0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        cfg_write(CFG_CHANNEL_INDEX, 2'd0);
        cfg_write(CFG_SPECIAL_MODE, 2'd0);
        test_table_load();
        test_note_clamp();
        test_volume_envelope();
        test_effects();
        test_chip_mode();
        test_backpressure();
        test_source_pause();
        test_random();
        settle();
        if (mismatches == 0 && tick_results_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
src/tct_pkg.sv
src/tct_period_ram.sv
src/tct_front.sv
src/tct_engine.sv
src/tracker_channel_tick.sv
tb/sv/testbench.sv
